### rtl/nlfc_pkg.sv
// ----------------------------------------------------------------------------
// nlfc_pkg
// Shared types and constants of the NMEA line framer and checksum checker.
// ----------------------------------------------------------------------------
package nlfc_pkg;

	localparam int COUNT_BITS      = 10;
	localparam int OVERFLOW_FACTOR = 4;
	localparam int CMP_W           = COUNT_BITS + 4;

	localparam logic [7:0] MIN_LINE      = 8'd16;
	localparam logic [7:0] RESET_MAX_LEN = 8'd82;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_STAR  = 3'd1,
		ST_BAD_LEN  = 3'd2,
		ST_NON_HEX  = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       is_nl;
		logic       is_dollar;
		logic       is_star;
		logic       is_blank;
		logic       hex_ok;
		logic [3:0] nibble;
	} item_t;

endpackage

### rtl/nmea_line_framer_checksum.sv
// ----------------------------------------------------------------------------
// nmea_line_framer_checksum
// Frames NMEA sentences from a byte stream and checks their checksum.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | rx_byte
//  output   | out_valid/out_stall | status, computed_checksum,
//           |                     | received_checksum, sentence_length
//  config   | cfg_we              | cfg_wdata (max_line_length)
//
// One byte per cycle sustained while in_stall and out_stall stay low. A byte
// passes the classifier, waits in the 4-word queue and is consumed by the
// line engine; a result shows in the output register the cycle after the
// engine takes its newline. in_stall rises only when the queue is full; the
// line engine stops while a result is held by out_stall. Reset clears the
// queue and the line state and sets max_line_length to 82.
module nmea_line_framer_checksum (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] computed_checksum,
	output logic [7:0] received_checksum,
	output logic [7:0] sentence_length
);
	import nlfc_pkg::*;

	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_full;
	logic  q_not_empty;
	item_t q_head;

	nlfc_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	nlfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	nlfc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_not_empty       (q_not_empty),
		.q_head            (q_head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum),
		.sentence_length   (sentence_length)
	);

endmodule

### rtl/nlfc_front.sv
// ----------------------------------------------------------------------------
// nlfc_front
// Input side: accepts bytes and tags them as newline, dollar, star, blank
// or hex digit before they enter the queue.
// ----------------------------------------------------------------------------
module nlfc_front (
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     rx_byte,
	input  logic           q_full,
	output logic           push,
	output nlfc_pkg::item_t push_item
);
	import nlfc_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.data      = rx_byte;
		push_item.is_nl     = (rx_byte == CH_NL);
		push_item.is_dollar = (rx_byte == CH_DOLLAR);
		push_item.is_star   = (rx_byte == CH_STAR);
		push_item.is_blank  = (rx_byte == CH_SPACE) || (rx_byte inside {[8'h09:8'h0D]});
		push_item.hex_ok    = 1'b1;
		push_item.nibble    = 4'd0;
		if (rx_byte inside {[8'h30:8'h39]}) begin
			push_item.nibble = rx_byte[3:0];
		end else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			push_item.nibble = 4'(rx_byte[3:0] + 4'd9);
		end else begin
			push_item.hex_ok = 1'b0;
		end
	end

endmodule

### rtl/nlfc_queue.sv
// ----------------------------------------------------------------------------
// nlfc_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module nlfc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nlfc_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output nlfc_pkg::item_t head
);
	import nlfc_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

### rtl/nlfc_back.sv
// ----------------------------------------------------------------------------
// nlfc_back
// Line engine: tracks XOR, lengths and the star position of a sentence and
// on newline loads a status word into the output register if not too long.
// ----------------------------------------------------------------------------
module nlfc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            q_not_empty,
	input  nlfc_pkg::item_t q_head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      status,
	output logic [7:0]      computed_checksum,
	output logic [7:0]      received_checksum,
	output logic [7:0]      sentence_length
);
	import nlfc_pkg::*;

	typedef enum logic [1:0] {
		HUNT = 2'b01,
		LINE = 2'b10
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} digit_t;

	phase_t                phase_q;
	logic [7:0]            max_len_q;
	logic [7:0]            xor_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] trim_q;
	logic [COUNT_BITS-1:0] star_idx_q;
	logic                  star_q;
	digit_t                dig1_q;
	digit_t                dig2_q;

	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [7:0]            comp_q;
	logic [7:0]            recv_q;
	logic [7:0]            len_q;

	logic [7:0]            eff_max;
	logic [CMP_W-1:0]      limit;
	logic [CMP_W-1:0]      cnt_inc;
	logic                  ovf;
	logic                  too_long;
	logic [2:0]            res_status;
	logic [7:0]            res_comp;
	logic [7:0]            res_recv;

	assign pop       = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign status            = status_q;
	assign computed_checksum = comp_q;
	assign received_checksum = recv_q;
	assign sentence_length   = len_q;

	assign eff_max  = (max_len_q < MIN_LINE) ? MIN_LINE : max_len_q;
	assign limit    = CMP_W'(eff_max) * CMP_W'(OVERFLOW_FACTOR);
	assign cnt_inc  = CMP_W'(count_q) + CMP_W'(1);
	assign ovf      = (count_q == {COUNT_BITS{1'b1}}) || (cnt_inc > limit);
	assign too_long = CMP_W'(trim_q) > CMP_W'(eff_max);

	always_comb begin
		res_status = ST_OK;
		res_comp   = 8'd0;
		res_recv   = 8'd0;
		if (!star_q) begin
			res_status = ST_NO_STAR;
		end else if (CMP_W'(star_idx_q) + CMP_W'(3) != CMP_W'(trim_q)) begin
			res_status = ST_BAD_LEN;
		end else if (!dig1_q.ok || !dig2_q.ok) begin
			res_status = ST_NON_HEX;
		end else begin
			res_recv   = {dig1_q.nib, dig2_q.nib};
			res_comp   = xor_q;
			res_status = (xor_q == {dig1_q.nib, dig2_q.nib}) ? ST_OK : ST_MISMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= RESET_MAX_LEN;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= HUNT;
			xor_q       <= '0;
			count_q     <= '0;
			trim_q      <= '0;
			star_idx_q  <= '0;
			star_q      <= 1'b0;
			dig1_q      <= '0;
			dig2_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			comp_q      <= '0;
			recv_q      <= '0;
			len_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (phase_q)
					HUNT: begin
						if (q_head.is_dollar) begin
							phase_q    <= LINE;
							xor_q      <= '0;
							count_q    <= COUNT_BITS'(1);
							trim_q     <= COUNT_BITS'(1);
							star_idx_q <= '0;
							star_q     <= 1'b0;
							dig1_q     <= '0;
							dig2_q     <= '0;
						end
					end
					LINE: begin
						if (q_head.is_nl) begin
							phase_q <= HUNT;
							if (!too_long) begin
								out_valid_q <= 1'b1;
								status_q    <= res_status;
								comp_q      <= res_comp;
								recv_q      <= res_recv;
								len_q       <= trim_q[7:0];
							end
						end else if (ovf) begin
							// runaway line: give up and hunt
							phase_q <= HUNT;
						end else begin
							count_q <= cnt_inc[COUNT_BITS-1:0];
							if (!star_q) begin
								if (q_head.is_star) begin
									star_q     <= 1'b1;
									star_idx_q <= count_q;
								end else begin
									xor_q <= xor_q ^ q_head.data;
								end
							end else if (CMP_W'(count_q) == CMP_W'(star_idx_q) + CMP_W'(1)) begin
								dig1_q <= '{ok: q_head.hex_ok, nib: q_head.nibble};
							end else if (CMP_W'(count_q) == CMP_W'(star_idx_q) + CMP_W'(2)) begin
								dig2_q <= '{ok: q_head.hex_ok, nib: q_head.nibble};
							end
							if (!q_head.is_blank) begin
								trim_q <= cnt_inc[COUNT_BITS-1:0];
							end
						end
					end
					default: begin
						phase_q <= HUNT;
					end
				endcase
			end
		end
	end

endmodule

### dv/nmea_line_framer_checksum_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_line_framer_checksum_tb
// Self-checking bench for the NMEA line framer. Sentences of every kind
// (good, bad sum, missing star, short or long sum, non-hex, no dollar,
// near the length limit, runaway lines) are streamed byte by byte under
// several max_line_length values. A line predictor built into the
// scoreboard works out each result, which is checked field by field.
// ----------------------------------------------------------------------------

module nmea_line_framer_checksum_tb;
	import nlfc_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] comp;
		logic [7:0] recv;
		logic [7:0] len;
	} line_result_t;

	localparam int COUNT_TOP = (1 << COUNT_BITS) - 1;

	class line_checker;
		logic [7:0]   max_len;
		bit           in_line;
		logic [7:0]   run_xor;
		int           byte_cnt;
		int           trim_cnt;
		int           star_pos;
		bit           star_seen;
		logic [7:0]   digit_hi;
		logic [7:0]   digit_lo;
		line_result_t expected_lines[$];
		int           errors;
		int           checked;

		function new();
			max_len   = RESET_MAX_LEN;
			in_line   = 1'b0;
			run_xor   = 8'h00;
			byte_cnt  = 0;
			trim_cnt  = 0;
			star_pos  = 0;
			star_seen = 1'b0;
			digit_hi  = 8'h00;
			digit_lo  = 8'h00;
			errors    = 0;
			checked   = 0;
		endfunction

		function void set_max_len(logic [7:0] v);
			max_len = v;
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction

		function bit is_space(logic [7:0] b);
			return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
		endfunction

		function int nibble_of(logic [7:0] b);
			if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
			if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
			if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
			return -1;
		endfunction

		// advance the line state by one accepted word, queue a result on a newline unless the line is too long
		function void note_byte(logic [7:0] b);
			int           lim;
			int           pos;
			int           hi;
			int           lo;
			line_result_t r;
			lim = (max_len < MIN_LINE) ? int'(MIN_LINE) : int'(max_len);
			if (!in_line) begin
				if (b == CH_DOLLAR) begin
					in_line   = 1'b1;
					run_xor   = 8'h00;
					byte_cnt  = 1;
					trim_cnt  = 1;
					star_pos  = 0;
					star_seen = 1'b0;
					digit_hi  = 8'h00;
					digit_lo  = 8'h00;
				end
				return;
			end
			if (b == CH_NL) begin
				in_line = 1'b0;
				if (trim_cnt > lim) return;
				r = '0;
				r.len = 8'(trim_cnt);
				hi = nibble_of(digit_hi);
				lo = nibble_of(digit_lo);
				if (!star_seen) begin
					r.status = ST_NO_STAR;
				end else if (star_pos + 3 != trim_cnt) begin
					r.status = ST_BAD_LEN;
				end else if (hi < 0 || lo < 0) begin
					r.status = ST_NON_HEX;
				end else begin
					r.recv = 8'(hi * 16 + lo);
					r.comp = run_xor;
					if (r.comp == r.recv)
						r.status = ST_OK;
					else
						r.status = ST_MISMATCH;
				end
				expected_lines = {expected_lines, r};
				return;
			end
			// runaway line: give up and hunt again
			if (byte_cnt >= COUNT_TOP || byte_cnt + 1 > OVERFLOW_FACTOR * lim) begin
				in_line = 1'b0;
				return;
			end
			pos = byte_cnt;
			byte_cnt++;
			if (!star_seen) begin
				if (b == CH_STAR) begin
					star_seen = 1'b1;
					star_pos  = pos;
				end else begin
					run_xor ^= b;
				end
			end else if (pos == star_pos + 1) begin
				digit_hi = b;
			end else if (pos == star_pos + 2) begin
				digit_lo = b;
			end
			if (!is_space(b))
				trim_cnt = byte_cnt;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("ERROR %0t: %s", $time, msg);
		endtask

		task check_result(logic [2:0] st, logic [7:0] comp, logic [7:0] recv, logic [7:0] len);
			line_result_t want;
			checked++;
			if (expected_lines.size() == 0) begin
				report($sformatf("unexpected result status %0d len %0d", st, len));
				return;
			end
			want = expected_lines.pop_front();
			if (st != want.status)
				report($sformatf("status %0d, want %0d (len %0d)", st, want.status, want.len));
			if (comp != want.comp)
				report($sformatf("computed_checksum %02h, want %02h", comp, want.comp));
			if (recv != want.recv)
				report($sformatf("received_checksum %02h, want %02h", recv, want.recv));
			if (len != want.len)
				report($sformatf("sentence_length %0d, want %0d", len, want.len));
		endtask
	endclass

	typedef enum int {
		LN_GOOD,
		LN_BAD_SUM,
		LN_NO_STAR,
		LN_SHORT_SUM,
		LN_LONG_SUM,
		LN_BAD_HEX,
		LN_NO_DOLLAR,
		LN_NEAR_MAX,
		LN_OVERFLOW
	} line_kind_t;

	localparam int NUM_PHASES      = 6;
	localparam int PHASE_BYTES     = 50;
	localparam int DRAIN_CYCLES    = 16;
	localparam int WATCHDOG_CYCLES = 2000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] computed_checksum;
	logic [7:0] received_checksum;
	logic [7:0] sentence_length;

	line_checker board = new();
	logic [7:0]  cur_max = RESET_MAX_LEN;
	bit          in_gaps  = 1'b1;
	bit          out_gaps = 1'b1;
	int          bytes_sent = 0;
	int          quiet_cycles = 0;

	nmea_line_framer_checksum u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum),
		.sentence_length   (sentence_length)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// result monitor, receiver back-pressure and watchdog
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(status, computed_checksum, received_checksum, sentence_length);
		out_stall <= out_gaps && ($urandom_range(0, 99) < 24);
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
			$display("nmea_line_framer_checksum regression: fail");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (in_gaps && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic stop_input();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_max_len(input logic [7:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_max_len(v);
		cur_max = v;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10) return 8'h30 + {4'h0, n};
		return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 4))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0B;
			3: return 8'h0C;
			default: return 8'h0D;
		endcase
	endfunction

	// sentence body: mostly printable, some '$', blanks, controls, high bytes
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0: c = CH_DOLLAR;
			1: c = blank_char();
			2: c = 8'($urandom_range(128, 255));
			3: begin
				c = 8'($urandom_range(0, 31));
				if (c == CH_NL) c = 8'h00;
			end
			default: begin
				do c = 8'($urandom_range(33, 126)); while (c == CH_STAR);
			end
		endcase
		return c;
	endfunction

	function automatic line_kind_t pick_kind(int eff);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return LN_GOOD;
		if (r < 50) return LN_BAD_SUM;
		if (r < 57) return LN_NO_STAR;
		if (r < 63) return LN_SHORT_SUM;
		if (r < 69) return LN_LONG_SUM;
		if (r < 77) return LN_BAD_HEX;
		if (r < 82) return LN_NO_DOLLAR;
		if (r < 88) return (eff <= 90) ? LN_NEAR_MAX : LN_GOOD;
		if (r < 92) return (eff <= 24) ? LN_OVERFLOW : LN_BAD_SUM;
		return LN_GOOD;
	endfunction

	task automatic send_line(input line_kind_t kind);
		logic [7:0] q[$];
		logic [7:0] xsum;
		logic [7:0] shown;
		logic [7:0] c;
		int         eff;
		int         body;
		int         n;
		bit         lower;
		eff   = (cur_max < MIN_LINE) ? int'(MIN_LINE) : int'(cur_max);
		xsum  = 8'h00;
		lower = 1'($urandom_range(0, 1));
		// garbage while hunting
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (n) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_DOLLAR) c = 8'hFF;
			q = {q, c};
		end
		if (kind == LN_NO_DOLLAR) begin
			repeat ($urandom_range(1, 6)) begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR);
				q = {q, c};
			end
			q = {q, CH_NL};
		end else begin
			q = {q, CH_DOLLAR};
			case (kind)
				LN_NEAR_MAX: body = eff - 5 + $urandom_range(0, 3);
				LN_OVERFLOW: body = OVERFLOW_FACTOR * eff - 2 + $urandom_range(0, 3);
				default:     body = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				                                                : $urandom_range(0, 12);
			endcase
			repeat (body) begin
				c = body_char();
				q = {q, c};
				xsum ^= c;
			end
			case (kind)
				LN_NO_STAR: ;
				LN_OVERFLOW: begin
					// short clean sentence right behind shows whether the line was abandoned
					q = {q, CH_DOLLAR, CH_STAR, hex_char(4'h0, lower), hex_char(4'h0, lower)};
				end
				LN_SHORT_SUM: begin
					q = {q, CH_STAR};
					if ($urandom_range(0, 1) != 0) q = {q, hex_char(xsum[7:4], lower)};
				end
				LN_BAD_HEX: begin
					q = {q, CH_STAR};
					do c = 8'($urandom_range(0, 255));
					while (board.nibble_of(c) >= 0 || board.is_space(c) || c == CH_NL);
					n = $urandom_range(0, 2);
					q = {q, (n == 1) ? hex_char(xsum[7:4], lower) : c};
					q = {q, (n == 2) ? hex_char(xsum[3:0], lower) : c};
				end
				default: begin
					shown = (kind == LN_BAD_SUM) ? xsum ^ 8'($urandom_range(1, 255)) : xsum;
					q = {q, CH_STAR, hex_char(shown[7:4], lower), hex_char(shown[3:0], lower)};
					if (kind == LN_LONG_SUM)
						repeat ($urandom_range(1, 2)) q = {q, 8'($urandom_range(33, 126))};
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) q = {q, blank_char()};
			q = {q, CH_NL};
		end
		foreach (q[i]) send_byte(q[i]);
	endtask

	initial begin
		int         start;
		logic [7:0] v;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ok, newline while hunting, extreme bytes, lowercase mismatch,
		// missing star, non-hex digit, one-digit checksum
		send_text("$A*41\n");
		send_text("\n");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_text("$a*6f\n$\n$*G0\n$*1\n");

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: v = MIN_LINE;
					2: v = 8'hFF;
					3: v = 8'd5;
					4: v = 8'($urandom_range(17, 64));
					default: v = 8'h00;
				endcase
				write_max_len(v);
			end
			// one phase runs with both sides flat out
			in_gaps  = (ph != 4);
			out_gaps = (ph != 4);
			if (ph == 2) send_line(LN_NEAR_MAX);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				send_line(pick_kind((cur_max < MIN_LINE) ? int'(MIN_LINE) : int'(cur_max)));
				if ($urandom_range(0, 24) == 0) begin
					stop_input();
					wait_drained();
				end
			end
			stop_input();
			wait_drained();
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		if (board.pending() != 0)
			board.report($sformatf("%0d results never arrived", board.pending()));
		$display("covered: %0d words over %0d max_line_length settings, %0d results checked",
		         bytes_sent, NUM_PHASES, board.checked);
		if (board.errors == 0)
			$display("nmea_line_framer_checksum regression: pass");
		else
			$display("nmea_line_framer_checksum regression: fail");
		$finish;
	end

endmodule
